@@ src/hlpd_pkg.sv @@
// Shared types and constants for the header/length packet deframer.
// No dependencies; the interfaces and the top module import this package.
`timescale 1ns / 1ps
`default_nettype none

package hlpd_pkg;

  // Default sizing of the block
  localparam int HeaderLenDefault    = 2;
  localparam int PayloadDepthDefault = 32;

  // Field widths
  localparam int ByteW  = 8;
  localparam int LenW   = 7;
  localparam int IndexW = 6;

  // Configuration port
  localparam int CfgIndexW = 3;
  localparam int CfgDataW  = 8;

  localparam logic [CfgIndexW-1:0] REG_SYNC_BYTE_0 = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_SYNC_BYTE_1 = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_SYNC_BYTE_2 = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_SYNC_BYTE_3 = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_MAX_PAYLOAD = 3'd4;

  // Register reset values
  localparam logic [ByteW-1:0] SYNC_BYTE_0_RST = 8'hAA;
  localparam logic [ByteW-1:0] SYNC_BYTE_1_RST = 8'h55;
  localparam logic [ByteW-1:0] SYNC_BYTE_2_RST = 8'h00;
  localparam logic [ByteW-1:0] SYNC_BYTE_3_RST = 8'h00;
  localparam logic [LenW-1:0]  MAX_PAYLOAD_RST = 7'd32;

  // Result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_LEN = 1'b1;

endpackage

`default_nettype wire

@@ src/hlpd_in_if.sv @@
// Input channel of the deframer: one received byte per word.
// Depends on hlpd_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface hlpd_in_if import hlpd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ src/hlpd_out_if.sv @@
// Result channel of the deframer: one payload byte (or error) per word.
// Depends on hlpd_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface hlpd_out_if import hlpd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [ByteW-1:0]  command;
  logic [LenW-1:0]   frame_length;
  logic [ByteW-1:0]  data_byte;
  logic [IndexW-1:0] data_index;
  logic              last;

  modport source (output valid, output status, output command, output frame_length,
                  output data_byte, output data_index, output last, input ready);
  modport sink   (input valid, input status, input command, input frame_length,
                  input data_byte, input data_index, input last, output ready);
endinterface

`default_nettype wire

@@ src/header_len_packet_deframer_top.sv @@
// Header/length packet deframer. Header, command and payload bytes are accepted without stall
// and give no result; a length byte waits until the output register is free.
// A length byte that is too large or zero gives one result in the output register next cycle.
// The last payload byte starts a readout: each result is a RAM read, then a load into the output
// register that waits while the sink stalls; the input is held off until the last result is loaded.
// Reset (sync, active high) restores register defaults and search; the RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module header_len_packet_deframer_top import hlpd_pkg::*; #(
  parameter int HEADER_LEN    = HeaderLenDefault,
  parameter int PAYLOAD_DEPTH = PayloadDepthDefault
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIndexW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0]  cfg_wdata,
  hlpd_in_if.sink                   in_ch,
  hlpd_out_if.source                out_ch
);

  localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

  localparam logic [2:0] ST_SEARCH   = 3'd0;
  localparam logic [2:0] ST_COMMAND  = 3'd1;
  localparam logic [2:0] ST_LENGTH   = 3'd2;
  localparam logic [2:0] ST_PAYLOAD  = 3'd3;
  localparam logic [2:0] ST_DRAIN_RD = 3'd4;
  localparam logic [2:0] ST_DRAIN_LD = 3'd5;

  localparam logic [1:0]       HDR_LAST  = 2'(HEADER_LEN - 1);
  localparam logic [ByteW-1:0] DEPTH_LIM = ByteW'(PAYLOAD_DEPTH);

  // Configuration registers
  logic [ByteW-1:0] sync_byte [4];
  logic [LenW-1:0]  max_payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte[0] <= SYNC_BYTE_0_RST;
      sync_byte[1] <= SYNC_BYTE_1_RST;
      sync_byte[2] <= SYNC_BYTE_2_RST;
      sync_byte[3] <= SYNC_BYTE_3_RST;
      max_payload  <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_BYTE_0: sync_byte[0] <= cfg_wdata;
        REG_SYNC_BYTE_1: sync_byte[1] <= cfg_wdata;
        REG_SYNC_BYTE_2: sync_byte[2] <= cfg_wdata;
        REG_SYNC_BYTE_3: sync_byte[3] <= cfg_wdata;
        REG_MAX_PAYLOAD: max_payload  <= cfg_wdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  logic [2:0]       state;
  logic [1:0]       hdr_pos;
  logic [AW-1:0]    wr_pos;
  logic [AW-1:0]    rd_pos;
  logic [ByteW-1:0] held_command;
  logic [LenW-1:0]  held_length;

  // Output register
  logic              out_valid;
  logic              out_status;
  logic [ByteW-1:0]  out_command;
  logic [LenW-1:0]   out_length;
  logic [ByteW-1:0]  out_data;
  logic [IndexW-1:0] out_index;
  logic              out_last;

  logic             out_free;
  logic             out_load;
  logic             in_ready;
  logic             in_fire;
  logic [ByteW-1:0] b;
  logic [ByteW-1:0] limit;
  logic             len_bad;
  logic             wr_done;
  logic             rd_done;
  logic             ram_we;
  logic             ram_re;
  logic [ByteW-1:0] ram_rdata;

  assign out_free = !out_valid || out_ch.ready;
  assign in_ready = (state == ST_SEARCH) || (state == ST_COMMAND) ||
                    (state == ST_PAYLOAD) || ((state == ST_LENGTH) && out_free);
  assign in_fire  = in_ch.valid && in_ready;
  assign b        = in_ch.rx_byte;

  // Effective length limit and frame end checks
  assign limit   = ({1'b0, max_payload} > DEPTH_LIM) ? DEPTH_LIM : {1'b0, max_payload};
  assign len_bad = b > limit;
  assign wr_done = (LenW'(wr_pos) + LenW'(1)) >= held_length;
  assign rd_done = (LenW'(rd_pos) + LenW'(1)) == held_length;

  // Output register loads on a bad-length or zero-length result, or a readout word
  assign out_load = (in_fire && (state == ST_LENGTH) && (len_bad || (b == '0))) ||
                    ((state == ST_DRAIN_LD) && out_free);

  assign ram_we = in_fire && (state == ST_PAYLOAD);
  assign ram_re = (state == ST_DRAIN_RD);

  hlpd_ram #(
    .WIDTH (ByteW),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_pos),
    .wdata (b),
    .re    (ram_re),
    .raddr (rd_pos),
    .rdata (ram_rdata)
  );

  // Frame parser and readout sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_SEARCH;
      hdr_pos      <= '0;
      wr_pos       <= '0;
      rd_pos       <= '0;
      held_command <= '0;
      held_length  <= '0;
      out_valid    <= 1'b0;
    end else begin
      // valid set on a load, cleared once the word is taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_SEARCH: begin
          if (in_fire) begin
            if (b == sync_byte[hdr_pos]) begin
              if (hdr_pos == HDR_LAST) begin
                hdr_pos <= '0;
                state   <= ST_COMMAND;
              end else begin
                hdr_pos <= hdr_pos + 2'd1;
              end
            end else begin
              hdr_pos <= '0;
            end
          end
        end
        ST_COMMAND: begin
          if (in_fire) begin
            held_command <= b;
            state        <= ST_LENGTH;
          end
        end
        ST_LENGTH: begin
          if (in_fire) begin
            wr_pos <= '0;
            if (len_bad) begin
              out_status  <= STATUS_BAD_LEN;
              out_command <= '0;
              out_length  <= '0;
              out_data    <= '0;
              out_index   <= '0;
              out_last    <= 1'b1;
              state       <= ST_SEARCH;
            end else if (b == '0) begin
              held_length <= '0;
              out_status  <= STATUS_OK;
              out_command <= held_command;
              out_length  <= '0;
              out_data    <= '0;
              out_index   <= '0;
              out_last    <= 1'b1;
              state       <= ST_SEARCH;
            end else begin
              held_length <= b[LenW-1:0];
              state       <= ST_PAYLOAD;
            end
          end
        end
        ST_PAYLOAD: begin
          if (in_fire) begin
            if (wr_done) begin
              wr_pos <= '0;
              rd_pos <= '0;
              state  <= ST_DRAIN_RD;
            end else begin
              wr_pos <= wr_pos + AW'(1);
            end
          end
        end
        ST_DRAIN_RD: begin
          state <= ST_DRAIN_LD;
        end
        ST_DRAIN_LD: begin
          // read data is held until the output register frees up
          if (out_free) begin
            out_status  <= STATUS_OK;
            out_command <= held_command;
            out_length  <= held_length;
            out_data    <= ram_rdata;
            out_index   <= IndexW'(rd_pos);
            out_last    <= rd_done;
            if (rd_done) begin
              state <= ST_SEARCH;
            end else begin
              rd_pos <= rd_pos + AW'(1);
              state  <= ST_DRAIN_RD;
            end
          end
        end
        default: begin
          state <= ST_SEARCH;
        end
      endcase
    end
  end

  // Channel outputs
  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_status;
  assign out_ch.command      = out_command;
  assign out_ch.frame_length = out_length;
  assign out_ch.data_byte    = out_data;
  assign out_ch.data_index   = out_index;
  assign out_ch.last         = out_last;

endmodule

`default_nettype wire

@@ src/hlpd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module hlpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
